### design/lsab_pkg.sv
`timescale 1ns / 1ps

package lsab_pkg;

    // Field widths of the channels
    localparam int COORD_BITS = 16;
    localparam int OP_W       = 2;
    localparam int BEAM_W     = 7;
    localparam int DIST_W     = 34;

    // Default beam count and range register reset (5 m squared, Q18.16)
    localparam int              BEAMS_DEF   = 128;
    localparam logic [DIST_W-1:0] RANGE_RESET = 34'd1638400;

    // Bearing unit: 15 vectoring steps, angle in turn units (65536 = full turn)
    localparam int CORDIC_STEPS = 15;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int ROT_W        = 32;
    localparam int ANG_W        = 18;
    localparam int ATAN_W       = 14;
    localparam int MUL_W        = 18;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SQX,
        S_SQY,
        S_ROT,
        S_BIN,
        S_FETCH,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [BEAM_W-1:0]            beam_sel;
    } in_t;

    typedef struct packed {
        logic [BEAM_W-1:0] beam;
        logic [DIST_W-1:0] dist_sq;
        logic              hit;
        logic              in_range;
    } out_t;

    // Arctangent of 2^-i in turn units
    function automatic logic [ATAN_W-1:0] turn_atan(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            case (idx)
                4'd0:    val = 14'd8192;
                4'd1:    val = 14'd4836;
                4'd2:    val = 14'd2555;
                4'd3:    val = 14'd1297;
                4'd4:    val = 14'd651;
                4'd5:    val = 14'd326;
                4'd6:    val = 14'd163;
                4'd7:    val = 14'd81;
                4'd8:    val = 14'd41;
                4'd9:    val = 14'd20;
                4'd10:   val = 14'd10;
                4'd11:   val = 14'd5;
                4'd12:   val = 14'd3;
                4'd13:   val = 14'd1;
                4'd14:   val = 14'd1;
                default: val = 14'd0;
            endcase
            return val;
        end
    endfunction

endpackage

### design/lsab_ram.sv
`timescale 1ns / 1ps

module lsab_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/lsab_cordic.sv
`timescale 1ns / 1ps

module lsab_cordic
    import lsab_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic signed [ANG_W-1:0]  angle,
    output logic                     done
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [ROT_W-1:0]  x_reg, x_next;
    logic signed [ROT_W-1:0]  y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;

    logic signed [ROT_W-1:0]  x_init, y_init, x_sh, y_sh;
    logic signed [ANG_W-1:0]  atan_val;

    always_comb
    begin
        // Scale the difference vector into the rotator range
        x_init   = ROT_W'(dx) <<< 12;
        y_init   = ROT_W'(dy) <<< 12;
        x_sh     = x_reg >>> step_reg;
        y_sh     = y_reg >>> step_reg;
        atan_val = ANG_W'(turn_atan(step_reg));

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        priority if (load)
        begin
            // Fold the left half plane onto the right, half a turn each way
            busy_next = 1'b1;
            step_next = '0;
            if (dx < 0)
            begin
                x_next = -x_init;
                y_next = -y_init;
                z_next = (dy < 0) ? -ANG_W'(32768) : ANG_W'(32768);
            end
            else
            begin
                x_next = x_init;
                y_next = y_init;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            // Rotate toward the x axis and accumulate the angle
            if (!y_reg[ROT_W-1])
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_val;
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            // Hold the rotator while idle
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign done  = done_reg;

endmodule

### design/laser_scan_angular_binning.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Beat
// in        input      in_valid/in_stall   in_t: op, pos_x, pos_y, beam_sel
// out       output     out_valid/out_stall out_t: beam, dist_sq, hit, in_range
// cfg       input      cfg_we              range_sq, written directly
//
// Add point: runs the 15 steps of the iterative bearing rotator plus squaring,
// binning and a read-modify-write of the beam memory.
// Read beam: a read of the beam memory. Start: a sweep clearing the beam memory.
// After reset the same sweep runs before the first beat is taken.
// A result waits in the output register under out_stall; the next beat is taken
// meanwhile, and the block holds at its end until the output register is free.
module laser_scan_angular_binning
    import lsab_pkg::*;
#(
    parameter int BEAMS = BEAMS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              cfg_we,
    input  logic [DIST_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(BEAMS);
    localparam int BW    = $clog2(BEAMS + 1);
    localparam int RAM_W = DIST_W + 1;

    state_t                       state_reg, state_next;
    logic                         item_reg, item_next;
    logic [AW-1:0]                clr_reg, clr_next;
    logic [DIST_W-1:0]            range_reg;
    logic                         out_valid_reg, out_valid_next;
    out_t                         out_data_reg, out_data_next;

    logic [OP_W-1:0]              op_reg, op_next;
    logic [BEAM_W-1:0]            sel_reg, sel_next;
    logic signed [COORD_BITS-1:0] sensor_x_reg, sensor_x_next;
    logic signed [COORD_BITS-1:0] sensor_y_reg, sensor_y_next;
    logic signed [DIFF_W-1:0]     dx_reg, dx_next;
    logic signed [DIFF_W-1:0]     dy_reg, dy_next;
    logic [DIST_W-1:0]            dist_reg, dist_next;
    logic [BW-1:0]                bin_reg, bin_next;
    logic                         zero_reg, zero_next;
    logic                         hit_reg, hit_next;
    logic                         inr_reg, inr_next;

    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [2*MUL_W-1:0]    prod;
    logic [2*MUL_W-1:0]           bin_sum;
    logic signed [ANG_W:0]        u_full;
    logic [16:0]                  u_clamp;
    logic                         in_ok, sel_ok;
    logic                         out_free;

    logic                         rot_load, rot_done;
    logic signed [ANG_W-1:0]      rot_angle;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [RAM_W-1:0]             ram_wdata, ram_rdata;
    logic                         rd_hit;
    logic [DIST_W-1:0]            rd_dist;

    lsab_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (rot_load),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .angle (rot_angle),
        .done  (rot_done)
    );

    // Beam memory: hit flag over nearest squared distance
    lsab_ram #(
        .WIDTH (RAM_W),
        .DEPTH (BEAMS)
    ) u_beam_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_hit  = ram_rdata[RAM_W-1];
    assign rd_dist = ram_rdata[DIST_W-1:0];

    // Shared multiplier
    assign prod = mul_a * mul_b;

    always_comb
    begin
        // Clamp the bearing to one turn starting at minus half a turn
        u_full = zero_reg ? (ANG_W + 1)'(32768)
                          : (ANG_W + 1)'(rot_angle) + (ANG_W + 1)'(32768);
        priority if (u_full < 0)
        begin
            u_clamp = '0;
        end
        else if (u_full > (ANG_W + 1)'(65536))
        begin
            u_clamp = 17'd65536;
        end
        else
        begin
            u_clamp = u_full[16:0];
        end
    end

    assign bin_sum  = prod + (2 * MUL_W)'(32768);
    assign in_ok    = (dist_reg <= range_reg) && (bin_reg < BW'(BEAMS));
    assign sel_ok   = 32'(sel_reg) < BEAMS;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        op_next        = op_reg;
        sel_next       = sel_reg;
        sensor_x_next  = sensor_x_reg;
        sensor_y_next  = sensor_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dist_next      = dist_reg;
        bin_next       = bin_reg;
        zero_next      = zero_reg;
        hit_next       = hit_reg;
        inr_next       = inr_reg;

        mul_a     = '0;
        mul_b     = '0;
        rot_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = AW'(bin_reg);

        // Drop the output beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the beam memory, one entry per cycle
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(BEAMS - 1))
                begin
                    clr_next   = '0;
                    state_next = item_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = 1'b1;
                    op_next   = in_data.op;
                    sel_next  = in_data.beam_sel;
                    dx_next   = DIFF_W'(in_data.pos_x) - DIFF_W'(sensor_x_reg);
                    dy_next   = DIFF_W'(in_data.pos_y) - DIFF_W'(sensor_y_reg);
                    dist_next = '0;
                    bin_next  = '0;
                    hit_next  = 1'b0;
                    inr_next  = 1'b0;
                    unique case (in_data.op)
                        OP_START:
                        begin
                            sensor_x_next = in_data.pos_x;
                            sensor_y_next = in_data.pos_y;
                            clr_next      = '0;
                            state_next    = S_CLEAR;
                        end
                        OP_ADD:
                        begin
                            state_next = S_SQX;
                        end
                        OP_READ:
                        begin
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SQX:
            begin
                // Square dx and start the bearing rotator
                mul_a      = MUL_W'(dx_reg);
                mul_b      = MUL_W'(dx_reg);
                dist_next  = DIST_W'(prod);
                rot_load   = 1'b1;
                zero_next  = (dx_reg == '0) && (dy_reg == '0);
                state_next = S_SQY;
            end

            S_SQY:
            begin
                mul_a      = MUL_W'(dy_reg);
                mul_b      = MUL_W'(dy_reg);
                dist_next  = dist_reg + DIST_W'(prod);
                state_next = S_ROT;
            end

            S_ROT:
            begin
                if (rot_done)
                begin
                    state_next = S_BIN;
                end
            end

            S_BIN:
            begin
                // Scale the turn fraction to a beam index, rounding half up
                mul_a      = MUL_W'(u_clamp);
                mul_b      = MUL_W'(BEAMS);
                bin_next   = BW'(bin_sum >> 16);
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                if (op_reg == OP_ADD)
                begin
                    ram_re     = in_ok;
                    inr_next   = in_ok;
                    state_next = in_ok ? S_UPDATE : S_DONE;
                end
                else
                begin
                    ram_re     = sel_ok;
                    ram_raddr  = AW'(sel_reg);
                    state_next = sel_ok ? S_UPDATE : S_DONE;
                end
            end

            S_UPDATE:
            begin
                if (op_reg == OP_ADD)
                begin
                    // Keep the strictly nearer point
                    if (!rd_hit || (dist_reg < rd_dist))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(bin_reg);
                        ram_wdata = {1'b1, dist_reg};
                        hit_next  = 1'b1;
                    end
                end
                else
                begin
                    hit_next  = rd_hit;
                    dist_next = rd_hit ? rd_dist : '0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            out_data_next.beam     = BEAM_W'(bin_reg);
                            out_data_next.dist_sq  = dist_reg;
                            out_data_next.hit      = hit_reg;
                            out_data_next.in_range = inr_reg;
                        end
                        OP_READ:
                        begin
                            out_data_next.beam    = sel_reg;
                            out_data_next.dist_sq = dist_reg;
                            out_data_next.hit     = hit_reg;
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            item_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            range_reg     <= RANGE_RESET;
            sensor_x_reg  <= '0;
            sensor_y_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            sensor_x_reg  <= sensor_x_next;
            sensor_y_reg  <= sensor_y_next;
            if (cfg_we)
            begin
                range_reg <= cfg_wdata;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        op_reg       <= op_next;
        sel_reg      <= sel_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dist_reg     <= dist_next;
        bin_reg      <= bin_next;
        zero_reg     <= zero_next;
        hit_reg      <= hit_next;
        inr_reg      <= inr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
